// ----- rtl/bmsea_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bmsea_pkg
// Types and constants of the byte memory with sized, endian-selectable access.
// ---------------------------------------------------------------------------
package bmsea_pkg;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 64;
    localparam int LANES   = 8;
    localparam int LANE_W  = 3;
    localparam int LEN_W   = 4;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [1:0]        access_size;
        logic              big_endian;
        logic [ADDR_W-1:0] byte_address;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              range_error;
    } t_rsp;

    function automatic logic [LEN_W-1:0] size_len(input logic [1:0] code);
        logic [LEN_W-1:0] len;
        case (code)
            SIZE_BYTE:  len = 4'd1;
            SIZE_WORD:  len = 4'd4;
            SIZE_DWORD: len = 4'd8;
            default:    len = 4'd0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/bmsea_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bmsea_ram
// Generic single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module bmsea_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

// ----- rtl/byte_memory_sized_endian_access_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// byte_memory_sized_endian_access_unit
// Byte-addressed memory split into eight byte banks; 1, 4 or 8 byte accesses
// at any address, little- or big-endian, with range checking.
// ---------------------------------------------------------------------------
// Pipeline: the r_s1_* registers hold the request while the banks read; r_rsp and r_valid follow.
// Throughput: one word per cycle while busy is low; the eight bank RAMs work in parallel and
// an unaligned access spans two rows by giving each bank its own row address.
// Reset: after i_rst_n a clearing pass zeroes one row of all banks per cycle,
// over min(ceil(MEM_BYTES/8), 8193) rows (8192 at the default), with busy high.
// The receiver cannot stall: o_valid is high for exactly one cycle per result.
// ---------------------------------------------------------------------------
module byte_memory_sized_endian_access_unit
    import bmsea_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    localparam int ROWS_ALL   = (MEM_BYTES + LANES - 1) / LANES;
    localparam int ROWS_REACH = (1 << ADDR_W) / LANES + 1;
    localparam int DEPTH      = (ROWS_ALL < ROWS_REACH) ? ROWS_ALL : ROWS_REACH;
    localparam int ROW_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BASE_W     = ADDR_W - LANE_W;

    logic             r_clearing;
    logic [ROW_W-1:0] r_clr_row;

    logic             r_s1_valid;
    logic             r_s1_write;
    logic             r_s1_err;
    logic [LANE_W-1:0] r_s1_ofs;
    logic [LEN_W-1:0] r_s1_len;
    logic             r_s1_big;

    logic             r_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic             w_accept;
    logic [LEN_W-1:0] w_len;
    logic [31:0]      w_end;
    logic             w_err;
    logic [LANE_W-1:0] w_ofs;
    logic [BASE_W-1:0] w_base;
    logic [BASE_W:0]  w_next;

    logic             w_we    [LANES];
    logic [ROW_W-1:0] w_row   [LANES];
    logic [7:0]       w_wbyte [LANES];
    logic [7:0]       w_q     [LANES];

    assign busy     = r_clearing;
    assign w_accept = start && !r_clearing;
    assign w_len    = size_len(i_req.access_size);
    assign w_end    = 32'(i_req.byte_address) + 32'(w_len);
    assign w_err    = (w_len == '0) || (w_end > 32'(MEM_BYTES));
    assign w_ofs    = i_req.byte_address[LANE_W-1:0];
    assign w_base   = i_req.byte_address[ADDR_W-1:LANE_W];
    assign w_next   = {1'b0, w_base} + 1'b1;

    always_comb begin
        logic [LANE_W-1:0] idx;
        logic [LEN_W-1:0]  pos;
        logic [DATA_W-1:0] shifted;
        for (int b = 0; b < LANES; b++) begin
            idx     = LANE_W'(LANE_W'(b) - w_ofs);
            pos     = i_req.big_endian ? LEN_W'(w_len - 1'b1 - {1'b0, idx})
                                       : {1'b0, idx};
            shifted = i_req.write_data >> {pos[LANE_W-1:0], 3'b000};
            if (r_clearing) begin
                w_we[b]    = 1'b1;
                w_row[b]   = r_clr_row;
                w_wbyte[b] = '0;
            end else begin
                w_we[b]    = w_accept && (i_req.req_type == REQ_WRITE) && !w_err
                             && ({1'b0, idx} < w_len);
                w_row[b]   = (LANE_W'(b) >= w_ofs) ? ROW_W'(w_base) : ROW_W'(w_next);
                w_wbyte[b] = shifted[7:0];
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_bank
        bmsea_ram #(
            .WIDTH  (8),
            .DEPTH  (DEPTH),
            .ADDR_W (ROW_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_addr  (w_row[g]),
            .i_wdata (w_wbyte[g]),
            .o_rdata (w_q[g])
        );
    end

    always_comb begin
        logic [LEN_W-1:0]  idx;
        logic [LANE_W-1:0] src;
        n_rsp.range_error = r_s1_err;
        n_rsp.read_data   = '0;
        for (int j = 0; j < LANES; j++) begin
            idx = r_s1_big ? LEN_W'(r_s1_len - 1'b1 - LEN_W'(j)) : LEN_W'(j);
            src = LANE_W'(r_s1_ofs + idx[LANE_W-1:0]);
            if (!r_s1_write && !r_s1_err && (LEN_W'(j) < r_s1_len)) begin
                n_rsp.read_data[8*j +: 8] = w_q[src];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
            r_s1_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_row == ROW_W'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_row <= ROW_W'(r_clr_row + 1'b1);
            end
            r_s1_valid <= w_accept;
            r_valid    <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_write <= i_req.req_type;
            r_s1_err   <= w_err;
            r_s1_ofs   <= w_ofs;
            r_s1_len   <= w_len;
            r_s1_big   <= i_req.big_endian;
        end
        if (r_s1_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule
`default_nettype wire
